### rtl/fpa_pkg.sv
// Shared types, constants and helpers for the fixed-point ALU.
// Used by fpa_front, fpa_queue, fpa_back and fixed_point_alu; no dependencies.
package fpa_pkg;

   localparam int FRACTION_BITS = 8;
   localparam int WORD_WIDTH    = 32;
   localparam int FIELD_W       = 32;
   localparam int EW            = (WORD_WIDTH > FIELD_W) ? FIELD_W : WORD_WIDTH;
   localparam int PW            = 2 * EW;
   localparam int QW            = EW + FRACTION_BITS + 1;
   localparam int SAT_W         = (PW > QW) ? PW : QW;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [EW-1:0]    WORD_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0]    WORD_MIN = {1'b1, {(EW-1){1'b0}}};
   localparam logic [SAT_W-1:0] MAG_LIM  = SAT_W'(1) << (EW - 1);

   typedef enum logic [3:0] {
      MODE_ADD  = 4'd0,
      MODE_SUB  = 4'd1,
      MODE_MUL  = 4'd2,
      MODE_DIV  = 4'd3,
      MODE_MIN  = 4'd4,
      MODE_MAX  = 4'd5,
      MODE_INC  = 4'd6,
      MODE_DEC  = 4'd7,
      MODE_FROM = 4'd8,
      MODE_TO   = 4'd9,
      MODE_CMP  = 4'd10
   } fpa_mode_type;

   typedef enum logic [1:0] {
      KIND_DONE = 2'd0,
      KIND_MUL  = 2'd1,
      KIND_DIV  = 2'd2
   } fpa_kind_type;

   typedef struct packed {
      fpa_kind_type         kind;
      logic [EW-1:0]        result;
      logic                 ovf;
      logic                 dbz;
      logic                 less;
      logic                 greater;
      logic                 equal;
      logic signed [EW-1:0] a;
      logic signed [EW-1:0] b;
   } fpa_item_type;

   typedef struct packed {
      logic [EW-1:0] value;
      logic          ovf;
   } fpa_sat_type;

   function automatic fpa_sat_type fpa_saturate(input logic [SAT_W-1:0] mag, input logic neg);
      fpa_sat_type      s;
      logic [SAT_W-1:0] lim;
      lim = neg ? MAG_LIM : MAG_LIM - SAT_W'(1);
      if (mag > lim) begin
         s.ovf   = 1'b1;
         s.value = neg ? WORD_MIN : WORD_MAX;
      end else begin
         s.ovf   = 1'b0;
         s.value = neg ? -mag[EW-1:0] : mag[EW-1:0];
      end
      return s;
   endfunction

endpackage

### rtl/fpa_front.sv
// Front end: accepts a transaction, decodes the mode and finishes the simple operations.
// Depends on fpa_pkg; feeds fpa_queue.
module fpa_front import fpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [3:0]          req_mode,
   input  logic [FIELD_W-1:0]  req_operand_a,
   input  logic [FIELD_W-1:0]  req_operand_b,
   input  logic                queue_full,
   output logic                busy,
   output logic                push,
   output fpa_item_type        push_item
);

   logic                 valid_ff, valid_in;
   fpa_item_type         item_ff, item_in;
   logic                 accept;
   logic signed [EW-1:0] a, b;
   logic signed [EW:0]   sum, addend;
   logic [EW-1:0]        mag_a;
   fpa_sat_type          sat;

   assign busy      = valid_ff & queue_full;
   assign accept    = start & ~busy;
   assign push      = valid_ff & ~queue_full;
   assign push_item = item_ff;
   assign a         = req_operand_a[EW-1:0];
   assign b         = req_operand_b[EW-1:0];
   assign mag_a     = a[EW-1] ? -a : a;

   always_comb begin
      case (fpa_mode_type'(req_mode))
         MODE_SUB: addend = -{b[EW-1], b};
         MODE_INC: addend = (EW+1)'(1);
         MODE_DEC: addend = -(EW+1)'(1);
         default:  addend = {b[EW-1], b};
      endcase
      sum = {a[EW-1], a} + addend;
      sat = fpa_saturate(SAT_W'(mag_a) << FRACTION_BITS, a[EW-1]);

      item_in         = '0;
      item_in.kind    = KIND_DONE;
      item_in.a       = a;
      item_in.b       = b;
      item_in.less    = a < b;
      item_in.greater = a > b;
      item_in.equal   = a == b;
      unique case (fpa_mode_type'(req_mode)) inside
         MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC: begin
            item_in.ovf    = sum[EW] ^ sum[EW-1];
            item_in.result = item_in.ovf ? (sum[EW] ? WORD_MIN : WORD_MAX) : sum[EW-1:0];
         end
         MODE_MUL: item_in.kind = KIND_MUL;
         MODE_DIV: begin
            if (b == '0) begin
               item_in.dbz = 1'b1;
            end else begin
               item_in.kind = KIND_DIV;
            end
         end
         MODE_MIN: item_in.result = (a < b) ? a : b;
         MODE_MAX: item_in.result = (a < b) ? b : a;
         MODE_FROM: begin
            item_in.result = sat.value;
            item_in.ovf    = sat.ovf;
         end
         MODE_TO:  item_in.result = a >>> FRACTION_BITS;
         MODE_CMP: item_in.result = '0;
         default:  item_in.result = '0;
      endcase

      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

### rtl/fpa_queue.sv
// Short FIFO of decoded transactions between the front end and the back end.
// Depends on fpa_pkg.
module fpa_queue import fpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  fpa_item_type push_item,
   input  logic         pop,
   output fpa_item_type pop_item,
   output logic         full,
   output logic         empty
);

   fpa_item_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_pop;

   assign full     = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_pop   = pop & ~empty;
   assign pop_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

### rtl/fpa_back.sv
// Back end: pipelined multiplier, one-bit-per-stage divider and final rounding.
// Depends on fpa_pkg; takes transactions from fpa_queue.
module fpa_back import fpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  fpa_item_type in_item,
   output logic         rsp_valid,
   output logic [EW-1:0] rsp_result,
   output logic         rsp_less,
   output logic         rsp_greater,
   output logic         rsp_equal,
   output logic         rsp_overflow,
   output logic         rsp_divide_by_zero
);

   typedef struct packed {
      fpa_item_type  item;
      logic [EW-1:0] rem;
      logic [QW-1:0] sh;
      logic [EW-1:0] d;
      logic          neg;
   } fpa_stage_type;

   logic                 p_valid_ff;
   fpa_item_type         p_item_ff;
   logic signed [PW-1:0] p_ff;
   logic                 dv_ff [QW+1];
   fpa_stage_type        dr_ff [QW+1];
   fpa_stage_type        r_in;
   logic [PW-1:0]        pmag, pround;
   fpa_sat_type          msat, dsat;
   logic [EW-1:0]        mag_a, mag_b;
   logic [QW:0]          qsum;
   fpa_stage_type        last;
   logic                 out_valid_ff;
   fpa_item_type         out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
      end
      p_item_ff <= in_item;
      p_ff      <= PW'(in_item.a) * PW'(in_item.b);
   end

   always_comb begin
      pmag   = p_ff[PW-1] ? -p_ff : p_ff;
      pround = (pmag + PW'(1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      msat   = fpa_saturate(SAT_W'(pround), p_ff[PW-1]);
      mag_a  = p_item_ff.a[EW-1] ? -p_item_ff.a : p_item_ff.a;
      mag_b  = p_item_ff.b[EW-1] ? -p_item_ff.b : p_item_ff.b;
      r_in      = '0;
      r_in.item = p_item_ff;
      r_in.sh   = QW'(mag_a) << (FRACTION_BITS + 1);
      r_in.d    = mag_b;
      r_in.neg  = p_item_ff.a[EW-1] ^ p_item_ff.b[EW-1];
      if (p_item_ff.kind == KIND_MUL) begin
         r_in.item.result = msat.value;
         r_in.item.ovf    = msat.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= p_valid_ff;
      end
      dr_ff[0] <= r_in;
   end

   for (genvar i = 0; i < QW; i++) begin : g_div
      logic [EW:0]   trial;
      logic          ge;
      fpa_stage_type nxt;
      always_comb begin
         trial  = {dr_ff[i].rem, dr_ff[i].sh[QW-1]};
         ge     = trial >= {1'b0, dr_ff[i].d};
         nxt    = dr_ff[i];
         nxt.rem = ge ? EW'(trial - {1'b0, dr_ff[i].d}) : trial[EW-1:0];
         nxt.sh  = {dr_ff[i].sh[QW-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i+1] <= 1'b0;
         end else begin
            dv_ff[i+1] <= dv_ff[i];
         end
         dr_ff[i+1] <= nxt;
      end
   end

   always_comb begin
      last = dr_ff[QW];
      qsum = (QW+1)'(last.sh) + (QW+1)'(1);
      dsat = fpa_saturate(SAT_W'(qsum[QW:1]), last.neg);
      if (last.item.kind == KIND_DIV) begin
         last.item.result = dsat.value;
         last.item.ovf    = dsat.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_ff[QW];
      end
      out_item_ff <= last.item;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result         = out_item_ff.result;
   assign rsp_less           = out_item_ff.less;
   assign rsp_greater        = out_item_ff.greater;
   assign rsp_equal          = out_item_ff.equal;
   assign rsp_overflow       = out_item_ff.ovf;
   assign rsp_divide_by_zero = out_item_ff.dbz;

endmodule

### rtl/fixed_point_alu.sv
// Top level of the signed fixed-point ALU: front end, queue and back end.
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
//
// A transaction is accepted at a clock edge where start is high and busy is low,
// carrying req_mode, req_operand_a and req_operand_b. Each transaction gives one
// result, shown on the rsp_ ports for exactly one cycle while rsp_valid is high.
// Every mode travels through the divider, which resolves one quotient bit per
// stage for a quotient of QW bits, where QW is the word width plus the fraction
// bits plus one, that is 41 bits with the default Q24.8 format. As all modes
// share this one path, results leave in order.
// A new transaction can be taken every cycle while busy is low: one per cycle.
// The back end never stalls, so busy stays low in normal use; it rises only if
// the queue were ever full while the front end holds a transaction.
// The receiver cannot stall: a result must be taken in the cycle it is shown.
// A synchronous reset empties the front end, queue and pipeline; transactions in
// flight are dropped and no rsp_valid pulse follows.
module fixed_point_alu import fpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_mode,
   input  logic [FIELD_W-1:0] req_operand_a,
   input  logic [FIELD_W-1:0] req_operand_b,
   output logic               rsp_valid,
   output logic [FIELD_W-1:0] rsp_result,
   output logic               rsp_less,
   output logic               rsp_greater,
   output logic               rsp_equal,
   output logic               rsp_overflow,
   output logic               rsp_divide_by_zero
);

   logic          push, pop, queue_full, queue_empty;
   fpa_item_type  push_item, pop_item;
   logic [EW-1:0] result_ew;

   fpa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_mode      (req_mode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .queue_full    (queue_full),
      .busy          (busy),
      .push          (push),
      .push_item     (push_item)
   );

   fpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign pop = ~queue_empty;

   fpa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (pop),
      .in_item            (pop_item),
      .rsp_valid          (rsp_valid),
      .rsp_result         (result_ew),
      .rsp_less           (rsp_less),
      .rsp_greater        (rsp_greater),
      .rsp_equal          (rsp_equal),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   assign rsp_result = FIELD_W'(signed'(result_ew));

`ifndef SYNTH
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_less, rsp_greater, rsp_equal}))
      else $error("comparator flags not exactly one");

   a_dbz_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result == '0 && !rsp_overflow))
      else $error("divide by zero result not clean");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("activity right after reset");
`endif

endmodule

### tb/fixed_point_alu_tb.sv
// Self-checking testbench for the signed fixed-point ALU (fixed_point_alu).
// Depends on fpa_pkg; predicts each result in the testbench and compares it in order.
`timescale 1ns / 1ps

module fixed_point_alu_tb;
   import fpa_pkg::*;

   typedef struct {
      logic [3:0]  mode;
      logic [31:0] a;
      logic [31:0] b;
   } alu_op_type;

   typedef struct {
      logic [31:0] result;
      logic        less;
      logic        greater;
      logic        equal;
      logic        overflow;
      logic        dbz;
   } alu_res_type;

   localparam int LATENCY   = QW + 5;
   localparam int WDOG_MAX  = 20000;
   localparam int NUM_RAND  = 1880;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_mode;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic        rsp_valid;
   logic [31:0] rsp_result;
   logic        rsp_less;
   logic        rsp_greater;
   logic        rsp_equal;
   logic        rsp_overflow;
   logic        rsp_divide_by_zero;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int          error_count = 0;
   int          idle_cycles;
   int          gap_left;
   bit          stimulus_done;
   bit          drain_wait;

   fixed_point_alu dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid),
      .rsp_result(rsp_result),
      .rsp_less(rsp_less),
      .rsp_greater(rsp_greater),
      .rsp_equal(rsp_equal),
      .rsp_overflow(rsp_overflow),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_word(input longint v, inout logic ovf);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (EW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         ovf = 1'b1;
         return hi;
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic alu_res_type compute_alu(input alu_op_type op);
      alu_res_type res;
      longint   a;
      longint   b;
      longint   r;
      longint   p;
      longint   m;
      longint   n;
      longint   d;
      logic     ovf;
      logic     dbz;
      a = longint'($signed(op.a[EW-1:0]));
      b = longint'($signed(op.b[EW-1:0]));
      r = 0;
      ovf = 1'b0;
      dbz = 1'b0;
      case (op.mode)
         MODE_ADD: r = clamp_word(a + b, ovf);
         MODE_SUB: r = clamp_word(a - b, ovf);
         MODE_MUL: begin
            p = a * b;
            m = (p < 0) ? -p : p;
            m = (m + (longint'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
            r = clamp_word((p < 0) ? -m : m, ovf);
         end
         MODE_DIV: begin
            if (b == 0) begin
               dbz = 1'b1;
            end else begin
               n = ((a < 0) ? -a : a) <<< FRACTION_BITS;
               d = (b < 0) ? -b : b;
               m = (2 * n + d) / (2 * d);
               r = clamp_word(((a < 0) != (b < 0)) ? -m : m, ovf);
            end
         end
         MODE_MIN: r = (a < b) ? a : b;
         MODE_MAX: r = (a < b) ? b : a;
         MODE_INC: r = clamp_word(a + 1, ovf);
         MODE_DEC: r = clamp_word(a - 1, ovf);
         MODE_FROM: begin
            m = (a < 0) ? -a : a;
            m = m <<< FRACTION_BITS;
            r = clamp_word((a < 0) ? -m : m, ovf);
         end
         MODE_TO: r = a >>> FRACTION_BITS;
         default: r = 0;
      endcase
      res.result   = r[31:0];
      res.less     = a < b;
      res.greater  = a > b;
      res.equal    = a == b;
      res.overflow = ovf;
      res.dbz      = dbz;
      return res;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 4096)) - 2048);
         4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         5: return 32'($signed($urandom_range(0, 131072)) - 65536) <<< FRACTION_BITS;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_op(input logic [3:0] mode, input logic [31:0] a, input logic [31:0] b);
      alu_op_type op;
      op.mode = mode;
      op.a = a;
      op.b = b;
      pending_ops.push_back(op);
   endtask

   initial begin
      alu_op_type op;
      add_op(MODE_ADD, 32'h7fff_ffff, 32'h0000_0001);
      add_op(MODE_ADD, 32'h8000_0000, 32'hffff_ffff);
      add_op(MODE_SUB, 32'h8000_0000, 32'h0000_0001);
      add_op(MODE_SUB, 32'h7fff_ffff, 32'h8000_0000);
      add_op(MODE_MUL, 32'h0000_0180, 32'h0000_0080);
      add_op(MODE_MUL, 32'hffff_fe80, 32'h0000_0080);
      add_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
      add_op(MODE_MUL, 32'h7fff_ffff, 32'h8000_0000);
      add_op(MODE_DIV, 32'h0000_0100, 32'h0000_0000);
      add_op(MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
      add_op(MODE_DIV, 32'h0000_0001, 32'h0000_0200);
      add_op(MODE_DIV, 32'hffff_ffff, 32'h0000_0200);
      add_op(MODE_MIN, 32'h8000_0000, 32'h7fff_ffff);
      add_op(MODE_MAX, 32'h8000_0000, 32'h7fff_ffff);
      add_op(MODE_INC, 32'h7fff_ffff, 32'h0000_0000);
      add_op(MODE_DEC, 32'h8000_0000, 32'h0000_0000);
      add_op(MODE_FROM, 32'h0080_0000, 32'h0000_0000);
      add_op(MODE_FROM, 32'hff7f_ffff, 32'h0000_0000);
      add_op(MODE_TO, 32'hffff_ff01, 32'h0000_0000);
      add_op(MODE_TO, 32'h8000_0000, 32'h7fff_ffff);
      add_op(MODE_CMP, 32'h1234_5678, 32'h1234_5678);
      add_op(MODE_CMP, 32'hffff_ffff, 32'h0000_0000);
      add_op(4'd11, 32'hffff_ffff, 32'hffff_ffff);
      add_op(4'd15, 32'h0000_0000, 32'hffff_ffff);
      for (int i = 0; i < NUM_RAND; i++) begin
         op.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
         op.a = pick_operand();
         op.b = ($urandom_range(0, 15) == 0) ? 32'd0
              : ($urandom_range(0, 9) == 0) ? op.a : pick_operand();
         pending_ops.push_back(op);
      end
   end

   // Driver: random gaps between transactions, one wait for a full drain midway.
   always @(posedge clock) begin
      if (reset) begin
         start         <= 1'b0;
         req_mode      <= '0;
         req_operand_a <= '0;
         req_operand_b <= '0;
         gap_left      <= 0;
         drain_wait    <= 1'b0;
         stimulus_done <= 1'b0;
      end else if (!(start && busy)) begin
         if (pending_ops.size() == 1000 && !drain_wait) begin
            drain_wait <= 1'b1;
            start      <= 1'b0;
         end else if (drain_wait && pending_ops.size() == 1000
                      && expected_results.size() != 0) begin
            start <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            alu_op_type op;
            op = pending_ops.pop_front();
            start         <= 1'b1;
            req_mode      <= op.mode;
            req_operand_a <= op.a;
            req_operand_b <= op.b;
            if ($urandom_range(0, 2) == 0)
               gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80)
                                                        : $urandom_range(1, 3);
         end else begin
            start         <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // Monitor: records accepted transactions and checks results in order.
   always @(posedge clock) begin
      alu_res_type exp_res;
      alu_op_type  op;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy) begin
            op.mode = req_mode;
            op.a = req_operand_a;
            op.b = req_operand_b;
            expected_results.push_back(compute_alu(op));
         end
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result %h", rsp_result);
               error_count++;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_result !== exp_res.result) begin
                  $error("result: expected %h, actual %h", exp_res.result, rsp_result);
                  error_count++;
               end
               if (rsp_less !== exp_res.less) begin
                  $error("less: expected %b, actual %b", exp_res.less, rsp_less);
                  error_count++;
               end
               if (rsp_greater !== exp_res.greater) begin
                  $error("greater: expected %b, actual %b", exp_res.greater, rsp_greater);
                  error_count++;
               end
               if (rsp_equal !== exp_res.equal) begin
                  $error("equal: expected %b, actual %b", exp_res.equal, rsp_equal);
                  error_count++;
               end
               if (rsp_overflow !== exp_res.overflow) begin
                  $error("overflow: expected %b, actual %b", exp_res.overflow, rsp_overflow);
                  error_count++;
               end
               if (rsp_divide_by_zero !== exp_res.dbz) begin
                  $error("divide_by_zero: expected %b, actual %b", exp_res.dbz,
                         rsp_divide_by_zero);
                  error_count++;
               end
            end
         end
         if ((start && !busy) || rsp_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && expected_results.size() == 0)
             && idle_cycles < WDOG_MAX)
         @(posedge clock);
      if (idle_cycles >= WDOG_MAX) begin
         $display("fixed_point_alu_tb NOT OK");
      end else begin
         repeat (2 * LATENCY) @(posedge clock);
         if (error_count == 0)
            $display("fixed_point_alu_tb OK");
         else
            $display("fixed_point_alu_tb NOT OK");
      end
      $finish;
   end

endmodule
